// ----- rtl/bfm_pkg.sv -----
package bfm_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] MIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2    = 32'hc2b2ae35;

  localparam int unsigned WORD_BITS = 64;

  typedef struct packed {
    logic       op;
    logic [7:0] key_byte;
    logic       last;
  } bfm_in_t;

  typedef struct packed {
    logic        maybe_present;
    logic [31:0] item_count;
  } bfm_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_MOD,
    ST_MOD_FIX,
    ST_CHK_RD,
    ST_CHK_WT,
    ST_SET_RD,
    ST_SET_WR,
    ST_DONE
  } bfm_state_t;

endpackage

// ----- rtl/bfm_ram.sv -----
module bfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/bloom_filter_fnv_murmur_core.sv -----
// Bloom filter over streamed keys.
// Input channel: one key byte per beat; last marks the final byte and op
// (0 check, 1 add) is taken from that beat. Result channel: one beat per key
// with maybe_present and the saturating add count including this key.
// Each non-last byte is folded into the running hash by the FNV-1a step
// (xor, then multiply) while idle. After a last byte each probe runs the
// murmur finalizer through one multiplier (ST_MIX1 to ST_MIX3), the
// remainder by FILTER_BITS as a reciprocal multiply (ST_MOD) and a
// multiply-subtract (ST_MOD_FIX) and one read of the filter memory
// (ST_CHK_RD, ST_CHK_WT). An add then runs a read-modify-write of the
// filter word for each probe (ST_SET_RD, ST_SET_WR). The result register
// loads in ST_DONE once the output is free; in_stall is high till then.
// The filter is one single-port memory of ceil(FILTER_BITS/64) 64-bit words.
// Reset starts a clearing pass that zeroes every word (128 at the default
// size), during which in_stall stays high.
// A waiting result does not block new bytes: in_stall drops again once the
// result sits in the output register, and only the next key's result waits
// for out_stall to release it.
module bloom_filter_fnv_murmur_core #(
  parameter int NUM_HASHES  = 3,
  parameter int FILTER_BITS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bfm_pkg::bfm_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bfm_pkg::bfm_out_t  out_data
);

  import bfm_pkg::*;

  localparam int WORD_COUNT = (FILTER_BITS + 63) / 64;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int POS_W      = $clog2(FILTER_BITS);
  localparam int PW         = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam logic [63:0] RECIP =
    ((64'd1 << (32 + POS_W)) + 64'(FILTER_BITS) - 64'd1) / 64'(FILTER_BITS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic        RECIP_HI = RECIP[32];

  bfm_state_t        state_r, state_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [31:0]       mix_r, mix_nxt;
  logic [31:0]       quot_r, quot_nxt;
  logic [PW-1:0]     probe_r, probe_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              op_r, op_nxt;
  logic              present_r, present_nxt;
  logic [31:0]       count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  bfm_out_t          out_data_r, out_data_nxt;
  logic [POS_W-1:0]  pos_r [NUM_HASHES];

  logic              pos_we;
  logic [63:0]       mod_prod;
  logic [64:0]       mod_sum;
  logic [POS_W-1:0]  rem_val;
  logic [POS_W-1:0]  pos_cur;
  logic              probe_last;
  logic              out_free;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [63:0]       ram_wdata;
  logic [63:0]       ram_rdata;
  logic [31:0]       mix_in;
  logic [31:0]       cnt_upd;

  bfm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_filter_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pos_cur    = pos_r[probe_r];
  assign probe_last = (probe_r == PW'(NUM_HASHES - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // remainder by FILTER_BITS through a rounded-up reciprocal
  assign mod_prod = 64'(mix_r) * 64'(RECIP_LO);
  assign mod_sum  = {1'b0, mod_prod} + (RECIP_HI ? {1'b0, mix_r, 32'd0} : 65'd0);
  assign rem_val  = POS_W'(mix_r - quot_r * 32'(FILTER_BITS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(WORD_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_data.last) state_nxt = ST_MIX1;
      end
      ST_MIX1:    state_nxt = ST_MIX2;
      ST_MIX2:    state_nxt = ST_MIX3;
      ST_MIX3:    state_nxt = ST_MOD;
      ST_MOD:     state_nxt = ST_MOD_FIX;
      ST_MOD_FIX: state_nxt = ST_CHK_RD;
      ST_CHK_RD:  state_nxt = ST_CHK_WT;
      ST_CHK_WT: begin
        if (!probe_last)  state_nxt = ST_MIX1;
        else if (op_r)    state_nxt = ST_SET_RD;
        else              state_nxt = ST_DONE;
      end
      ST_SET_RD: state_nxt = ST_SET_WR;
      ST_SET_WR: state_nxt = probe_last ? ST_DONE : ST_SET_RD;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    hash_nxt      = hash_r;
    mix_nxt       = mix_r;
    quot_nxt      = quot_r;
    probe_nxt     = probe_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    present_nxt   = present_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pos_we        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(pos_cur >> 6);
    ram_wdata     = ram_rdata | (64'd1 << pos_cur[5:0]);
    mix_in        = hash_r + 32'(probe_r);
    cnt_upd       = (op_r && (count_r != '1)) ? count_r + 32'd1 : count_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          hash_nxt = (hash_r ^ {24'd0, in_data.key_byte}) * FNV_PRIME;
          if (in_data.last) begin
            op_nxt      = in_data.op;
            present_nxt = 1'b1;
            probe_nxt   = '0;
          end
        end
      end
      ST_MIX1: mix_nxt = (mix_in ^ (mix_in >> 16)) * MIX_C1;
      ST_MIX2: mix_nxt = (mix_r ^ (mix_r >> 13)) * MIX_C2;
      ST_MIX3: mix_nxt = mix_r ^ (mix_r >> 16);
      ST_MOD: begin
        quot_nxt = 32'(mod_sum >> (32 + POS_W));
      end
      ST_MOD_FIX: begin
        pos_we = 1'b1;
      end
      ST_CHK_RD: begin
      end
      ST_CHK_WT: begin
        present_nxt = present_r & ram_rdata[pos_cur[5:0]];
        probe_nxt   = probe_last ? '0 : probe_r + PW'(1);
      end
      ST_SET_RD: begin
      end
      ST_SET_WR: begin
        ram_we    = 1'b1;
        probe_nxt = probe_last ? '0 : probe_r + PW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.maybe_present = present_r;
          out_data_nxt.item_count    = cnt_upd;
          count_nxt                  = cnt_upd;
          hash_nxt                   = FNV_BASIS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      hash_r      <= FNV_BASIS;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      probe_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hash_r      <= hash_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      probe_r     <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r      <= mix_nxt;
    quot_r     <= quot_nxt;
    op_r       <= op_nxt;
    present_r  <= present_nxt;
    out_data_r <= out_data_nxt;
    if (pos_we) begin
      pos_r[probe_r] <= rem_val;
    end
  end

  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_SET_WR))
    else $error("filter memory written outside clear or set phase");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= $past(count_r))
    else $error("item count decreased");

  a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == ST_DONE) |=> $stable(out_data_r))
    else $error("pending result overwritten");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    probe_r <= PW'(NUM_HASHES - 1))
    else $error("probe index out of range");

  a_hash_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> hash_r == FNV_BASIS)
    else $error("running hash not restored after key");

endmodule
